@@ design/pfe_pkg.sv @@
// pfe_pkg: shared constants and types for the per-position point averager.
// Used by pfe_store, pfe_blend and pointwise_frame_ema. No dependencies.
`default_nettype none
package pfe_pkg;

   localparam int INDEX_W    = 16;
   localparam int MAX_POINTS = 1 << INDEX_W;
   localparam int COORD_W    = 32;
   localparam int WEIGHT_W   = 17;
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = COORD_W + WEIGHT_W + 1;
   localparam int SUM_W      = PROD_W + 1;

   localparam logic [WEIGHT_W-1:0] ONE_Q16      = WEIGHT_W'(1 << FRAC_W);
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(6554);
   localparam logic [SUM_W-1:0]    ROUND_HALF   = SUM_W'(1 << (FRAC_W - 1));
   localparam logic [INDEX_W-1:0]  LAST_INDEX   = INDEX_W'(MAX_POINTS - 1);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [INDEX_W-1:0]        index_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      logic      valid;
      index_type idx;
      logic      first;
      logic      last;
   } tag_type;

endpackage
`default_nettype wire

@@ design/pfe_store.sv @@
// pfe_store: mean store, one point per position, registered read.
// Forwards a write that lands on the same edge as the read. Uses pfe_pkg.
`default_nettype none
module pfe_store (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               rd_en,
   input  wire pfe_pkg::index_type rd_idx,
   input  wire logic               wr_en,
   input  wire pfe_pkg::index_type wr_idx,
   input  wire pfe_pkg::point_type wr_data,
   output pfe_pkg::point_type      rd_data
);

   pfe_pkg::point_type mem [pfe_pkg::MAX_POINTS];
   pfe_pkg::point_type rd_ff;
   pfe_pkg::point_type fwd_ff;
   logic               hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff  <= mem[rd_idx];
         fwd_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (rd_en) begin
         hit_ff <= wr_en && (wr_idx == rd_idx);
      end
   end

   assign rd_data = hit_ff ? fwd_ff : rd_ff;

endmodule
`default_nettype wire

@@ design/pfe_blend.sv @@
// pfe_blend: two-stage blend w*old + (1-w)*new with round half up; first frame passes new through.
// Stage 1 multiplies, stage 2 adds and rounds. Uses pfe_pkg.
`default_nettype none
module pfe_blend (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic [pfe_pkg::WEIGHT_W-1:0] weight,
   input  wire pfe_pkg::tag_type             tag_in,
   input  wire pfe_pkg::point_type           new_in,
   input  wire pfe_pkg::point_type           old_in,
   output pfe_pkg::tag_type                  s1_tag,
   output pfe_pkg::tag_type                  s2_tag,
   output pfe_pkg::point_type                result
);

   pfe_pkg::tag_type   s1_tag_ff, s2_tag_ff;
   pfe_pkg::point_type s1_new_ff, s2_new_ff;

   logic signed [pfe_pkg::PROD_W-1:0] pold_in [3];
   logic signed [pfe_pkg::PROD_W-1:0] pnew_in [3];
   logic signed [pfe_pkg::PROD_W-1:0] pold_ff [3];
   logic signed [pfe_pkg::PROD_W-1:0] pnew_ff [3];
   logic        [pfe_pkg::SUM_W-1:0]  sum    [3];
   pfe_pkg::coord_type                old_a  [3];
   pfe_pkg::coord_type                new_a  [3];
   pfe_pkg::coord_type                res_a  [3];

   logic signed [pfe_pkg::WEIGHT_W:0] w_s;
   logic signed [pfe_pkg::WEIGHT_W:0] inv_s;

   assign w_s   = signed'({1'b0, weight});
   assign inv_s = signed'({1'b0, pfe_pkg::ONE_Q16 - weight});

   assign old_a[0] = old_in.x;
   assign old_a[1] = old_in.y;
   assign old_a[2] = old_in.z;
   assign new_a[0] = s1_new_ff.x;
   assign new_a[1] = s1_new_ff.y;
   assign new_a[2] = s1_new_ff.z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pold_in[k] = w_s * old_a[k];
         pnew_in[k] = inv_s * new_a[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff.valid <= 1'b0;
         s2_tag_ff.valid <= 1'b0;
      end else if (en) begin
         s1_tag_ff.valid <= tag_in.valid;
         s2_tag_ff.valid <= s1_tag_ff.valid;
      end
      if (en) begin
         s1_tag_ff.idx   <= tag_in.idx;
         s1_tag_ff.first <= tag_in.first;
         s1_tag_ff.last  <= tag_in.last;
         s1_new_ff       <= new_in;
         s2_tag_ff.idx   <= s1_tag_ff.idx;
         s2_tag_ff.first <= s1_tag_ff.first;
         s2_tag_ff.last  <= s1_tag_ff.last;
         s2_new_ff       <= s1_new_ff;
         for (int k = 0; k < 3; k++) begin
            pold_ff[k] <= pold_in[k];
            pnew_ff[k] <= pnew_in[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum[k] = {{(pfe_pkg::SUM_W - pfe_pkg::PROD_W){pold_ff[k][pfe_pkg::PROD_W-1]}},
                   pold_ff[k]}
                + {{(pfe_pkg::SUM_W - pfe_pkg::PROD_W){pnew_ff[k][pfe_pkg::PROD_W-1]}},
                   pnew_ff[k]}
                + pfe_pkg::ROUND_HALF;
         res_a[k] = signed'(sum[k][pfe_pkg::FRAC_W +: pfe_pkg::COORD_W]);
      end
   end

   assign result = s2_tag_ff.first ? s2_new_ff
                 : pfe_pkg::point_type'{x: res_a[0], y: res_a[1], z: res_a[2]};
   assign s1_tag = s1_tag_ff;
   assign s2_tag = s2_tag_ff;

endmodule
`default_nettype wire

@@ design/pointwise_frame_ema.sv @@
// pointwise_frame_ema: top level, per-position moving average of point frames.
// Uses pfe_pkg, pfe_store and pfe_blend.
//
//   port group | direction | handshake          | carries
//   req_       | in        | req_valid/req_stall| in_x, in_y, in_z, last_point
//   rsp_       | out       | rsp_valid/rsp_stall| mean_x, mean_y, mean_z, frame_end
//   csr_       | in        | csr_valid/csr_ready| mean_weight
//
// One point per cycle unless stalled; in a frame of one point each request waits
// while the previous one is in stage 1, as consecutive points then hit the same
// store entry (read/write interlock). Steps to rsp_valid: store read, multiply, add.
// A stalled response freezes the whole pipe including the store.
// Reset clears index and valid bits, sets first-frame flag, weight to WEIGHT_RESET; store not cleared.
`default_nettype none
module pointwise_frame_ema (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire pfe_pkg::coord_type           req_in_x,
   input  wire pfe_pkg::coord_type           req_in_y,
   input  wire pfe_pkg::coord_type           req_in_z,
   input  wire logic                         req_last_point,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output pfe_pkg::coord_type                rsp_mean_x,
   output pfe_pkg::coord_type                rsp_mean_y,
   output pfe_pkg::coord_type                rsp_mean_z,
   output logic                              rsp_frame_end,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [pfe_pkg::WEIGHT_W-1:0] csr_mean_weight
);

   logic [pfe_pkg::WEIGHT_W-1:0] weight_ff;
   logic [pfe_pkg::WEIGHT_W-1:0] weight_sat;
   pfe_pkg::index_type           point_index_ff, point_index_in;
   logic                         first_frame_ff, first_frame_in;
   logic                         rsp_valid_ff;
   pfe_pkg::point_type           rsp_data_ff;
   logic                         rsp_last_ff;

   logic               en;
   logic               hazard;
   logic               req_accept;
   pfe_pkg::tag_type   tag_in, s1_tag, s2_tag;
   pfe_pkg::point_type new_pt, old_pt, result;

   assign en         = !rsp_valid_ff || !rsp_stall;
   assign hazard     = s1_tag.valid && (s1_tag.idx == point_index_ff);
   assign req_stall  = !en || hazard;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign weight_sat = (weight_ff > pfe_pkg::ONE_Q16) ? pfe_pkg::ONE_Q16 : weight_ff;

   assign new_pt = '{x: req_in_x, y: req_in_y, z: req_in_z};
   assign tag_in = '{valid: req_accept, idx: point_index_ff, first: first_frame_ff,
                     last: req_last_point};

   always_comb begin
      point_index_in = point_index_ff;
      first_frame_in = first_frame_ff;
      if (req_accept) begin
         if (req_last_point || point_index_ff == pfe_pkg::LAST_INDEX) begin
            point_index_in = '0;
         end else begin
            point_index_in = point_index_ff + 1'b1;
         end
         if (req_last_point) begin
            first_frame_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_index_ff <= '0;
         first_frame_ff <= 1'b1;
         weight_ff      <= pfe_pkg::WEIGHT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         point_index_ff <= point_index_in;
         first_frame_ff <= first_frame_in;
         if (csr_valid && csr_ready) begin
            weight_ff <= csr_mean_weight;
         end
         if (en) begin
            rsp_valid_ff <= s2_tag.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= result;
         rsp_last_ff <= s2_tag.last;
      end
   end

   pfe_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_idx  (point_index_ff),
      .wr_en   (en && s2_tag.valid),
      .wr_idx  (s2_tag.idx),
      .wr_data (result),
      .rd_data (old_pt)
   );

   pfe_blend u_blend (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .weight (weight_sat),
      .tag_in (tag_in),
      .new_in (new_pt),
      .old_in (old_pt),
      .s1_tag (s1_tag),
      .s2_tag (s2_tag),
      .result (result)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mean_x    = rsp_data_ff.x;
   assign rsp_mean_y    = rsp_data_ff.y;
   assign rsp_mean_z    = rsp_data_ff.z;
   assign rsp_frame_end = rsp_last_ff;

   a_first_frame_stays_clear: assert property (@(posedge clock) disable iff (reset)
      !first_frame_ff |=> !first_frame_ff)
      else $error("first-frame flag set again without reset");

   a_last_ends_first_frame: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_point |=> !first_frame_ff && point_index_ff == '0)
      else $error("frame end did not clear index and first-frame flag");

   a_no_same_entry_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !(req_accept && point_index_ff == $past(point_index_ff)))
      else $error("two requests on one store entry in consecutive cycles");

endmodule
`default_nettype wire
